// ===== hw/rtl/mop_pkg.sv =====
package mop_pkg;

    // Item kinds carried on the mode field
    localparam logic MODE_DRAW = 1'b0;
    localparam logic MODE_READ = 1'b1;

    // Frame store row: eight buffer bytes side by side
    localparam int ROW_BYTES = 8;
    localparam int ROW_BITS  = ROW_BYTES * 8;

    // Rec.601 luma weights, scaled by 256
    localparam logic [7:0] LUMA_R_COEF = 8'd77;
    localparam logic [7:0] LUMA_G_COEF = 8'd150;
    localparam logic [7:0] LUMA_B_COEF = 8'd29;

    localparam logic [7:0] LUMA_THRESHOLD_RESET = 8'd128;

    // Read result queue depth
    localparam int OUT_DEPTH = 3;

    typedef logic [1:0] out_ptr_t;
    typedef logic [1:0] out_count_t;

    // Decoded item, handed from the decoder to the frame store
    typedef struct packed {
        logic       is_read;   // read item: returns one word
        logic       clear;     // wipe the whole buffer before the write
        logic       wr_en;     // pixel lit and on screen
        logic       in_range;  // read address inside the buffer
        logic [2:0] lane;      // byte within the row
        logic [7:0] mask;      // bit to set within the byte
    } mop_op_t;

endpackage

// ===== hw/rtl/mono_oled_pixel_plotter.sv =====
// Pixel plotter for a page-ordered 1-bit OLED frame buffer.
// Input channel (in_valid/in_ready): one word per draw or read item.
//   A draw word optionally wipes the whole buffer, then sets one pixel if it
//   is on screen, not transparent and its luma reaches the threshold.
//   A read word returns one buffer byte on the output channel.
// Output channel (out_valid/out_ready): read_data, one word per read item,
//   in order. Draw words give nothing.
// Config channel (cfg_valid/cfg_data): luma threshold, always ready; write
//   it only while no item is in flight.
// Throughput: one item per cycle while in_ready is high. Each item is decoded
//   at the input, read-modify-written in the following cycle against a
//   64-bit-wide row memory, with the row being written forwarded to a
//   following item; a read result goes through the queue before it is offered.
// The buffer wipe needs no clearing pass: one valid flag per 8-byte row.
// Reset: threshold returns to 128 and the whole buffer reads as zero at
//   once; there is no clearing pass.
// Receiver stall: results wait in a three-word queue; in_ready falls only
//   when queued and in-flight read results would overfill it.
module mono_oled_pixel_plotter #(
    parameter int DISPLAY_WIDTH  = 128,
    parameter int DISPLAY_HEIGHT = 64
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [7:0]         cfg_data,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               mode,
    input  logic               clear_frame,
    input  logic signed [11:0] screen_x,
    input  logic signed [11:0] screen_y,
    input  logic [7:0]         palette_index,
    input  logic [15:0]        pixel_color,
    input  logic               has_transparency,
    input  logic [7:0]         transparent_index,
    input  logic [9:0]         read_address,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [7:0]         read_data
);

    import mop_pkg::*;

    localparam int PAGES     = (DISPLAY_HEIGHT + 7) / 8;
    localparam int BUF_BYTES = DISPLAY_WIDTH * PAGES;
    localparam int ROWS      = (BUF_BYTES + ROW_BYTES - 1) / ROW_BYTES;
    localparam int ROW_W     = ROWS > 1 ? $clog2(ROWS) : 1;

    logic [7:0]       luma_threshold_reg;
    mop_op_t          op;
    logic [ROW_W-1:0] row;
    logic             in_fire;
    logic             rd_valid;
    logic [7:0]       rd_data;
    out_count_t       out_count;

    // Threshold register
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            luma_threshold_reg <= LUMA_THRESHOLD_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            luma_threshold_reg <= cfg_data;
        end
    end

    // Room for every read result already accepted plus this one
    assign in_ready = ({1'b0, out_count} + 3'(rd_valid)) < 3'(OUT_DEPTH);
    assign in_fire  = in_valid && in_ready;

    mop_pixel_decode #(
        .DISPLAY_WIDTH  (DISPLAY_WIDTH),
        .DISPLAY_HEIGHT (DISPLAY_HEIGHT)
    ) u_decode (
        .mode              (mode),
        .clear_frame       (clear_frame),
        .screen_x          (screen_x),
        .screen_y          (screen_y),
        .palette_index     (palette_index),
        .pixel_color       (pixel_color),
        .has_transparency  (has_transparency),
        .transparent_index (transparent_index),
        .read_address      (read_address),
        .luma_threshold    (luma_threshold_reg),
        .op                (op),
        .row               (row)
    );

    mop_frame_store #(
        .DISPLAY_WIDTH  (DISPLAY_WIDTH),
        .DISPLAY_HEIGHT (DISPLAY_HEIGHT)
    ) u_store (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_fire  (in_fire),
        .op       (op),
        .row      (row),
        .rd_valid (rd_valid),
        .rd_data  (rd_data)
    );

    mop_out_fifo u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (rd_valid),
        .push_data (rd_data),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .read_data (read_data),
        .count     (out_count)
    );

endmodule

// ===== hw/rtl/mop_ram.sv =====
module mop_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 128
) (
    input  logic                                  clk,
    input  logic                                  we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // One write port, one registered read port; a read of the address
    // being written returns the old contents
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== hw/rtl/mop_pixel_decode.sv =====
module mop_pixel_decode #(
    parameter int DISPLAY_WIDTH  = 128,
    parameter int DISPLAY_HEIGHT = 64
) (
    input  logic                  mode,
    input  logic                  clear_frame,
    input  logic signed [11:0]    screen_x,
    input  logic signed [11:0]    screen_y,
    input  logic [7:0]            palette_index,
    input  logic [15:0]           pixel_color,
    input  logic                  has_transparency,
    input  logic [7:0]            transparent_index,
    input  logic [9:0]            read_address,
    input  logic [7:0]            luma_threshold,
    output mop_pkg::mop_op_t      op,
    output logic [(((DISPLAY_WIDTH * ((DISPLAY_HEIGHT + 7) / 8)) + 7) / 8 > 1 ?
                   $clog2(((DISPLAY_WIDTH * ((DISPLAY_HEIGHT + 7) / 8)) + 7) / 8) : 1)-1:0]
                                  row
);

    import mop_pkg::*;

    localparam int PAGES     = (DISPLAY_HEIGHT + 7) / 8;
    localparam int BUF_BYTES = DISPLAY_WIDTH * PAGES;
    localparam int ROWS      = (BUF_BYTES + ROW_BYTES - 1) / ROW_BYTES;
    localparam int ROW_W     = ROWS > 1 ? $clog2(ROWS) : 1;
    localparam int POS_W     = ROW_W + 3;

    logic [7:0]       r8;
    logic [7:0]       g8;
    logic [7:0]       b8;
    logic [15:0]      luma_sum;
    logic             lit;
    logic             on_screen;
    logic             transparent;
    logic             rd_in_range;
    logic [POS_W-1:0] draw_pos;
    logic [POS_W-1:0] rd_pos;
    logic [POS_W-1:0] pos;

    // RGB565 to 8-bit channels, low bits zero
    assign r8 = {pixel_color[15:11], 3'b000};
    assign g8 = {pixel_color[10:5], 2'b00};
    assign b8 = {pixel_color[4:0], 3'b000};

    // Weighted sum stays below 2^16 for any colour
    assign luma_sum = ({8'h00, r8} * {8'h00, LUMA_R_COEF})
                    + ({8'h00, g8} * {8'h00, LUMA_G_COEF})
                    + ({8'h00, b8} * {8'h00, LUMA_B_COEF});
    assign lit      = luma_sum[15:8] >= luma_threshold;

    // Clipping and transparency
    assign on_screen   = (screen_x >= 0) && (int'(screen_x) < DISPLAY_WIDTH) &&
                         (screen_y >= 0) && (int'(screen_y) < DISPLAY_HEIGHT);
    assign transparent = has_transparency && (palette_index == transparent_index);

    // Byte address: page * width + column
    assign draw_pos    = POS_W'(screen_y[11:3]) * POS_W'(DISPLAY_WIDTH) + POS_W'(screen_x);
    assign rd_in_range = int'(read_address) < BUF_BYTES;
    assign rd_pos      = rd_in_range ? POS_W'(read_address) : '0;
    assign pos         = (mode == MODE_READ) ? rd_pos : draw_pos;

    always_comb
    begin
        op.is_read  = (mode == MODE_READ);
        op.clear    = (mode == MODE_DRAW) && clear_frame;
        op.wr_en    = (mode == MODE_DRAW) && on_screen && !transparent && lit;
        op.in_range = rd_in_range;
        op.lane     = pos[2:0];
        op.mask     = 8'(1) << screen_y[2:0];
    end

    assign row = pos[POS_W-1:3];

endmodule

// ===== hw/rtl/mop_frame_store.sv =====
module mop_frame_store #(
    parameter int DISPLAY_WIDTH  = 128,
    parameter int DISPLAY_HEIGHT = 64
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_fire,
    input  mop_pkg::mop_op_t      op,
    input  logic [(((DISPLAY_WIDTH * ((DISPLAY_HEIGHT + 7) / 8)) + 7) / 8 > 1 ?
                   $clog2(((DISPLAY_WIDTH * ((DISPLAY_HEIGHT + 7) / 8)) + 7) / 8) : 1)-1:0]
                                  row,
    output logic                  rd_valid,
    output logic [7:0]            rd_data
);

    import mop_pkg::*;

    localparam int PAGES     = (DISPLAY_HEIGHT + 7) / 8;
    localparam int BUF_BYTES = DISPLAY_WIDTH * PAGES;
    localparam int ROWS      = (BUF_BYTES + ROW_BYTES - 1) / ROW_BYTES;
    localparam int ROW_W     = ROWS > 1 ? $clog2(ROWS) : 1;

    logic                s1_valid_reg;
    mop_op_t             s1_op_reg;
    logic [ROW_W-1:0]    s1_row_reg;
    logic                fwd_hit_reg;
    logic                fwd_hit_next;
    logic [ROW_BITS-1:0] fwd_data_reg;
    logic [ROWS-1:0]     row_valid_reg;
    logic [ROWS-1:0]     row_valid_next;
    logic [ROW_BITS-1:0] ram_q;
    logic [ROW_BITS-1:0] merged;
    logic [ROW_BITS-1:0] new_row;
    logic [ROW_BITS-1:0] rd_shift;
    logic                s1_wr;

    mop_ram #(
        .WIDTH (ROW_BITS),
        .DEPTH (ROWS)
    ) u_ram (
        .clk   (clk),
        .we    (s1_wr),
        .waddr (s1_row_reg),
        .wdata (new_row),
        .raddr (row),
        .rdata (ram_q)
    );

    // Current row contents: own clear, then write forwarded from the item
    // just ahead, then the memory word, with rows untouched since the last clear read as zero
    always_comb
    begin
        if (s1_op_reg.clear)
        begin
            merged = '0;
        end
        else if (fwd_hit_reg)
        begin
            merged = fwd_data_reg;
        end
        else if (row_valid_reg[s1_row_reg])
        begin
            merged = ram_q;
        end
        else
        begin
            merged = '0;
        end
    end

    assign new_row  = merged | (ROW_BITS'(s1_op_reg.mask) << {s1_op_reg.lane, 3'b000});
    assign s1_wr    = s1_valid_reg && s1_op_reg.wr_en;
    assign rd_shift = merged >> {s1_op_reg.lane, 3'b000};

    // Read result leaves in the cycle after acceptance
    assign rd_valid = s1_valid_reg && s1_op_reg.is_read;
    assign rd_data  = s1_op_reg.in_range ? rd_shift[7:0] : 8'h00;

    // Write under way to the row the new item reads: take it directly
    assign fwd_hit_next = s1_wr && (s1_row_reg == row);

    // Row flags: a wipe drops them all, a write then marks its own row
    always_comb
    begin
        row_valid_next = row_valid_reg;
        if (s1_valid_reg && s1_op_reg.clear)
        begin
            row_valid_next = '0;
        end
        if (s1_wr)
        begin
            row_valid_next[s1_row_reg] = 1'b1;
        end
    end

    // Read-modify-write stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            row_valid_reg <= '0;
            fwd_hit_reg   <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= in_fire;
            fwd_hit_reg   <= in_fire && fwd_hit_next;
            row_valid_reg <= row_valid_next;
        end
    end

    // Payload of the stage
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_op_reg    <= op;
            s1_row_reg   <= row;
            fwd_data_reg <= new_row;
        end
    end

endmodule

// ===== hw/rtl/mop_out_fifo.sv =====
module mop_out_fifo (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  logic [7:0]            push_data,
    input  logic                  out_ready,
    output logic                  out_valid,
    output logic [7:0]            read_data,
    output mop_pkg::out_count_t   count
);

    import mop_pkg::*;

    logic [7:0] mem_reg [OUT_DEPTH];
    out_ptr_t   wr_ptr_reg;
    out_ptr_t   wr_ptr_next;
    out_ptr_t   rd_ptr_reg;
    out_ptr_t   rd_ptr_next;
    out_count_t count_reg;
    out_count_t count_next;
    logic       pop;

    assign out_valid = (count_reg != '0);
    assign read_data = mem_reg[rd_ptr_reg];
    assign pop       = out_valid && out_ready;
    assign count     = count_reg;

    // Pointer and occupancy update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == out_ptr_t'(OUT_DEPTH - 1)) ? '0 : wr_ptr_reg + 2'd1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == out_ptr_t'(OUT_DEPTH - 1)) ? '0 : rd_ptr_reg + 2'd1;
        end
        count_next = count_reg + out_count_t'(push) - out_count_t'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== tb/tb_top.sv =====
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import mop_pkg::*;

    localparam int DISP_W      = 128;
    localparam int DISP_H      = 64;
    localparam int BUF_BYTES   = DISP_W * ((DISP_H + 7) / 8);
    localparam int STUCK_LIMIT = 2000;
    localparam int PHASES      = 11;
    localparam int PHASE_ITEMS = 100;

    // One input word, plus an optional typed-in read result
    typedef struct {
        logic        mode;
        logic        clear_frame;
        logic [11:0] screen_x;
        logic [11:0] screen_y;
        logic [7:0]  palette_index;
        logic [15:0] pixel_color;
        logic        has_transparency;
        logic [7:0]  transparent_index;
        logic [9:0]  read_address;
        bit          pinned;
        logic [7:0]  pinned_val;
    } plot_req_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [7:0]         cfg_data = 8'h00;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic               mode = MODE_DRAW;
    logic               clear_frame = 1'b0;
    logic signed [11:0] screen_x = 12'sd0;
    logic signed [11:0] screen_y = 12'sd0;
    logic [7:0]         palette_index = 8'h00;
    logic [15:0]        pixel_color = 16'h0000;
    logic               has_transparency = 1'b0;
    logic [7:0]         transparent_index = 8'h00;
    logic [9:0]         read_address = 10'h000;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic [7:0]         read_data;

    // Shadow frame buffer and threshold
    logic [7:0] frame_mirror [0:BUF_BYTES-1] = '{default: 8'h00};
    logic [7:0] luma_floor = LUMA_THRESHOLD_RESET;
    logic [7:0] expected_bytes [$];

    plot_req_t  cur_req;
    plot_req_t  directed_rows [$];
    bit         steady = 1'b0;
    logic [9:0] last_plot_addr = 10'h000;
    int         faults = 0;
    int         stuck_cycles = 0;
    int         rx_wait = 0;
    int         rx_draw;

    mono_oled_pixel_plotter #(
        .DISPLAY_WIDTH (DISP_W),
        .DISPLAY_HEIGHT(DISP_H)
    ) i_dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_data         (cfg_data),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .mode             (mode),
        .clear_frame      (clear_frame),
        .screen_x         (screen_x),
        .screen_y         (screen_y),
        .palette_index    (palette_index),
        .pixel_color      (pixel_color),
        .has_transparency (has_transparency),
        .transparent_index(transparent_index),
        .read_address     (read_address),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .read_data        (read_data)
    );

    always #2 clk = ~clk;

    // Pause before a word; none at all during a steady stretch
    function automatic int idle_cycles();
        return steady ? 0 : $urandom_range(0, 16);
    endfunction

    function automatic void report_fault(input string msg);
        faults++;
        if (faults <= 10)
            $display("%0t: %s", $realtime, msg);
    endfunction

    // Shadow of one draw word: optional wipe, clip, transparency, luma test
    function automatic void plot_into_mirror(input plot_req_t w);
        int          sx;
        int          sy;
        int unsigned luma;
        sx = $signed(w.screen_x);
        sy = $signed(w.screen_y);
        if (w.clear_frame)
            foreach (frame_mirror[i])
                frame_mirror[i] = 8'h00;
        if (sx < 0 || sx >= DISP_W || sy < 0 || sy >= DISP_H)
            return;
        if (w.has_transparency && w.palette_index == w.transparent_index)
            return;
        luma = (int'(LUMA_R_COEF) * int'({w.pixel_color[15:11], 3'b000})
              + int'(LUMA_G_COEF) * int'({w.pixel_color[10:5], 2'b00})
              + int'(LUMA_B_COEF) * int'({w.pixel_color[4:0], 3'b000})) >> 8;
        if (luma >= int'(luma_floor))
            frame_mirror[(sy >> 3) * DISP_W + sx] |= 8'(1 << (sy & 7));
    endfunction

    function automatic plot_req_t draw_row(input int x, input int y, input logic [15:0] colour,
                                           input bit clr, input bit has_t,
                                           input logic [7:0] pal, input logic [7:0] t_idx);
        plot_req_t r;
        r.mode              = MODE_DRAW;
        r.clear_frame       = clr;
        r.screen_x          = 12'(x);
        r.screen_y          = 12'(y);
        r.palette_index     = pal;
        r.pixel_color       = colour;
        r.has_transparency  = has_t;
        r.transparent_index = t_idx;
        r.read_address      = 10'h000;
        r.pinned            = 1'b0;
        r.pinned_val        = 8'h00;
        return r;
    endfunction

    function automatic plot_req_t read_row(input int addr, input bit pinned,
                                           input logic [7:0] val);
        plot_req_t r;
        r              = draw_row(0, 0, 16'h0000, 1'b0, 1'b0, 8'h00, 8'h00);
        r.mode         = MODE_READ;
        r.read_address = 10'(addr);
        r.pinned       = pinned;
        r.pinned_val   = val;
        return r;
    endfunction

    // Mostly on-screen pixels, some clipped; reads lean on the last pixel drawn
    function automatic plot_req_t make_random_req();
        plot_req_t r;
        int        sx;
        int        sy;
        r = draw_row(0, 0, 16'($urandom), ($urandom_range(0, 49) == 0), 1'($urandom),
                     8'($urandom), 8'($urandom));
        r.mode     = ($urandom_range(0, 9) < 3) ? MODE_READ : MODE_DRAW;
        r.screen_x = ($urandom_range(0, 4) == 0) ? 12'($urandom)
                                                 : 12'($urandom_range(0, DISP_W - 1));
        r.screen_y = ($urandom_range(0, 4) == 0) ? 12'($urandom)
                                                 : 12'($urandom_range(0, DISP_H - 1));
        if ($urandom_range(0, 2) == 0)
            r.transparent_index = r.palette_index;
        if (r.mode == MODE_READ && $urandom_range(0, 1) == 1)
            r.read_address = last_plot_addr;
        else
            r.read_address = 10'($urandom);
        sx = $signed(r.screen_x);
        sy = $signed(r.screen_y);
        if (r.mode == MODE_DRAW && sx >= 0 && sx < DISP_W && sy >= 0 && sy < DISP_H)
            last_plot_addr = 10'((sy >> 3) * DISP_W + sx);
        return r;
    endfunction

    // Offer one word and hold it until taken; valid stays up afterwards
    task automatic send_req(input plot_req_t r);
        int gap;
        gap = idle_cycles();
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cur_req           <= r;
        in_valid          <= 1'b1;
        mode              <= r.mode;
        clear_frame       <= r.clear_frame;
        screen_x          <= r.screen_x;
        screen_y          <= r.screen_y;
        palette_index     <= r.palette_index;
        pixel_color       <= r.pixel_color;
        has_transparency  <= r.has_transparency;
        transparent_index <= r.transparent_index;
        read_address      <= r.read_address;
        do @(posedge clk); while (!in_ready);
    endtask

    // Stop sending, let every pending read come back, then wait out the given tail
    task automatic drain(input int tail);
        in_valid <= 1'b0;
        @(posedge clk);
        while (expected_bytes.size() != 0)
            @(posedge clk);
        repeat (tail) @(posedge clk);
    endtask

    // Predict on every accepted word, check every accepted result
    always @(posedge clk)
    begin
        plot_req_t  seen;
        logic [7:0] want;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
                luma_floor = cfg_data;
            if (in_valid && in_ready)
            begin
                seen                   = cur_req;
                seen.mode              = mode;
                seen.clear_frame       = clear_frame;
                seen.screen_x          = screen_x;
                seen.screen_y          = screen_y;
                seen.palette_index     = palette_index;
                seen.pixel_color       = pixel_color;
                seen.has_transparency  = has_transparency;
                seen.transparent_index = transparent_index;
                seen.read_address      = read_address;
                if (seen.mode == MODE_READ)
                    expected_bytes.push_back(cur_req.pinned ? cur_req.pinned_val
                                                            : frame_mirror[seen.read_address]);
                else
                    plot_into_mirror(seen);
            end
            if (out_valid && out_ready)
            begin
                if (expected_bytes.size() == 0)
                    report_fault($sformatf("read_data %02h with no read pending", read_data));
                else
                begin
                    want = expected_bytes.pop_front();
                    if (read_data !== want)
                        report_fault($sformatf("read_data mismatch: expected %02h, got %02h",
                                               want, read_data));
                end
            end
        end
    end

    // Result side: random stall after each word taken
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            rx_wait   <= 0;
        end
        else if (out_ready && out_valid)
        begin
            rx_draw = idle_cycles();
            if (rx_draw != 0)
            begin
                out_ready <= 1'b0;
                rx_wait   <= rx_draw - 1;
            end
        end
        else if (!out_ready)
        begin
            if (rx_wait == 0)
                out_ready <= 1'b1;
            else
                rx_wait <= rx_wait - 1;
        end
    end

    // Watchdog: too long with no handshake on any channel
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            stuck_cycles <= 0;
        else if (stuck_cycles == STUCK_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
        else
            stuck_cycles <= stuck_cycles + 1;
    end

    initial
    begin
        plot_req_t  r;
        logic [7:0] thr;
        int         phase;

        // Empty buffer after reset, both corners
        directed_rows.push_back(read_row(0, 1'b1, 8'h00));
        directed_rows.push_back(read_row(BUF_BYTES - 1, 1'b1, 8'h00));
        directed_rows.push_back(draw_row(0, 0, 16'hFFFF, 1'b0, 1'b0, 8'h00, 8'h00));
        directed_rows.push_back(draw_row(DISP_W - 1, DISP_H - 1, 16'hFFFF,
                                         1'b0, 1'b0, 8'h00, 8'h00));
        directed_rows.push_back(read_row(0, 1'b1, 8'h01));
        directed_rows.push_back(read_row(BUF_BYTES - 1, 1'b1, 8'h80));
        // Black stays dark
        directed_rows.push_back(draw_row(5, 9, 16'h0000, 1'b0, 1'b0, 8'h00, 8'h00));
        directed_rows.push_back(read_row(DISP_W + 5, 1'b1, 8'h00));
        // Off-screen pixels are dropped, no wrap into the next page
        directed_rows.push_back(draw_row(-1, 0, 16'hFFFF, 1'b0, 1'b0, 8'h00, 8'h00));
        directed_rows.push_back(draw_row(DISP_W, 0, 16'hFFFF, 1'b0, 1'b0, 8'h00, 8'h00));
        directed_rows.push_back(draw_row(2047, -2048, 16'hFFFF, 1'b0, 1'b0, 8'h00, 8'h00));
        directed_rows.push_back(draw_row(0, DISP_H, 16'hFFFF, 1'b0, 1'b0, 8'h00, 8'h00));
        directed_rows.push_back(read_row(DISP_W, 1'b1, 8'h00));
        // Transparency: matching index dropped, otherwise drawn
        directed_rows.push_back(draw_row(1, 0, 16'hFFFF, 1'b0, 1'b1, 8'h55, 8'h55));
        directed_rows.push_back(draw_row(2, 0, 16'hFFFF, 1'b0, 1'b1, 8'h54, 8'h55));
        directed_rows.push_back(draw_row(3, 0, 16'hFFFF, 1'b0, 1'b0, 8'h55, 8'h55));
        directed_rows.push_back(read_row(1, 1'b1, 8'h00));
        directed_rows.push_back(read_row(2, 1'b0, 8'h00));
        directed_rows.push_back(read_row(3, 1'b0, 8'h00));
        // Pure red and pure green against the reset threshold
        directed_rows.push_back(draw_row(10, 10, 16'hF800, 1'b0, 1'b0, 8'h00, 8'h00));
        directed_rows.push_back(draw_row(10, 11, 16'h07E0, 1'b0, 1'b0, 8'h00, 8'h00));
        directed_rows.push_back(read_row(DISP_W + 10, 1'b0, 8'h00));
        // Wipe on a dropped pixel, then wipe and draw
        directed_rows.push_back(draw_row(-5, -5, 16'hFFFF, 1'b1, 1'b0, 8'h00, 8'h00));
        directed_rows.push_back(read_row(BUF_BYTES - 1, 1'b1, 8'h00));
        directed_rows.push_back(draw_row(0, 0, 16'hFFFF, 1'b1, 1'b0, 8'h00, 8'h00));
        // Read word ignores the wipe flag and pixel fields
        r                   = read_row(0, 1'b1, 8'h01);
        r.clear_frame       = 1'b1;
        r.screen_x          = 12'h7FF;
        r.screen_y          = 12'h800;
        r.pixel_color       = 16'hFFFF;
        r.has_transparency  = 1'b1;
        r.palette_index     = 8'hFF;
        r.transparent_index = 8'hFF;
        directed_rows.push_back(r);

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
            send_req(directed_rows[i]);

        // Random phases, threshold changed between them while idle
        for (phase = 0; phase < PHASES; phase++)
        begin
            steady = ($urandom_range(0, 3) == 0);
            if (phase > 0)
            begin
                drain(4);
                case (phase)
                    1:       thr = 8'h00;
                    2:       thr = 8'hFF;
                    3:       thr = LUMA_THRESHOLD_RESET;
                    default: thr = 8'($urandom);
                endcase
                cfg_valid <= 1'b1;
                cfg_data  <= thr;
                do @(posedge clk); while (!cfg_ready);
                cfg_valid <= 1'b0;
            end
            repeat (PHASE_ITEMS) send_req(make_random_req());
        end

        drain(8);
        if (expected_bytes.size() != 0)
            report_fault($sformatf("%0d read results never arrived", expected_bytes.size()));

        if (faults == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
